// ===== hw/rtl/bwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded work-stealing deque package
// Shared types and default sizes for the bounded work-stealing deque unit.
// ----------------------------------------------------------------------------
package bwsd_pkg;

  // Default capacity of the deque in entries.
  localparam int unsigned DefaultDepth = 128;

  // Default number of task-word bits that are kept.
  localparam int unsigned DefaultDataWidth = 64;

  // Width of the task word field on the ports.
  localparam int unsigned WordWidth = 64;

  // Operation codes; code 3 is not defined and is ignored.
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2
  } cmd_e;

  // One request transaction.
  typedef struct packed {
    logic [1:0]           command;
    logic [WordWidth-1:0] push_data;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic                 ok;
    logic [WordWidth-1:0] pop_data;
  } rsp_t;

endpackage

// ===== hw/rtl/bwsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bwsd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bounded_work_stealing_deque_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded work-stealing deque unit
// A fixed-capacity ring of task words with owner push and pop at the bottom
// and steal at the top.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                       Handshake
//  request   start_i, busy_o, req_i      accepted when start_i && !busy_o
//  result    rsp_valid_o, rsp_o          one-cycle strobe, always accepted
//
// A request is accepted every cycle; busy_o is never raised.
// The result of a request appears in the cycle after it is accepted, set by the
// registered read port of the slot memory.
// Pointers are cleared by the asynchronous reset; slot contents are not.
// The receiver cannot stall, so no result is ever held back.
//
module bounded_work_stealing_deque_unit
  import bwsd_pkg::*;
#(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned PtrW = $clog2(2 * DEPTH);
  localparam logic [PtrW-1:0] PtrMax   = PtrW'(2 * DEPTH - 1);
  localparam logic [PtrW-1:0] DepthVal = PtrW'(DEPTH);
  localparam logic [PtrW:0]   PtrMod   = (PtrW + 1)'(2 * DEPTH);

  logic [PtrW-1:0] bot_q, bot_d;
  logic [PtrW-1:0] top_q, top_d;
  logic            rsp_valid_q;
  logic            ok_q, ok_d;
  logic [1:0]      op_q;

  logic            accept;
  logic [PtrW-1:0] occ;
  logic            empty;
  logic            full;
  logic [PtrW-1:0] bot_prev;
  logic [PtrW-1:0] top_next;
  logic [PtrW-1:0] bot_next;
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [WordWidth-1:0]  pop_ext;

  // Map a wrapping pointer onto its slot index.
  function automatic logic [IdxW-1:0] ptr_idx(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p >= DepthVal) ? (p - DepthVal) : p;
    return r[IdxW-1:0];
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Occupancy, full and empty from the two wrapping pointers.
  always_comb begin
    logic [PtrW:0] diff;
    diff = (bot_q >= top_q) ? ({1'b0, bot_q} - {1'b0, top_q})
                            : ({1'b0, bot_q} + PtrMod - {1'b0, top_q});
    occ   = diff[PtrW-1:0];
    empty = (bot_q == top_q);
    full  = (occ == DepthVal);
  end

  // Neighbor pointer values, wrapping modulo twice the depth.
  assign bot_next = (bot_q == PtrMax) ? '0 : bot_q + PtrW'(1);
  assign bot_prev = (bot_q == '0) ? PtrMax : bot_q - PtrW'(1);
  assign top_next = (top_q == PtrMax) ? '0 : top_q + PtrW'(1);

  // Pointer update and memory access for the accepted transaction.
  always_comb begin
    bot_d     = bot_q;
    top_d     = top_q;
    ok_d      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ptr_idx(bot_q);
    ram_raddr = ptr_idx(top_q);
    if (accept) begin
      case (req_i.command)
        CMD_PUSH: begin
          if (!full) begin
            ram_we = 1'b1;
            bot_d  = bot_next;
            ok_d   = 1'b1;
          end
        end
        CMD_POP: begin
          ram_raddr = ptr_idx(bot_prev);
          if (!empty) begin
            ram_re = 1'b1;
            ok_d   = 1'b1;
            // Taking the last entry moves top up so both pointers meet.
            if (bot_prev == top_q) begin
              top_d = bot_q;
            end else begin
              bot_d = bot_prev;
            end
          end
        end
        CMD_STEAL: begin
          if (!empty) begin
            ram_re = 1'b1;
            top_d  = top_next;
            ok_d   = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // Slot memory.
  bwsd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.push_data[DATA_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pointer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bot_q       <= '0;
      top_q       <= '0;
      rsp_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      op_q        <= CMD_PUSH;
    end else begin
      bot_q       <= bot_d;
      top_q       <= top_d;
      rsp_valid_q <= accept;
      ok_q        <= ok_d;
      op_q        <= req_i.command;
    end
  end

  // Result word: popped data only for a successful pop or steal.
  always_comb begin
    pop_ext = '0;
    pop_ext[DATA_WIDTH-1:0] = ram_rdata;
    rsp_o.ok       = ok_q;
    rsp_o.pop_data = (ok_q && (op_q != CMD_PUSH)) ? pop_ext : '0;
  end

  assign rsp_valid_o = rsp_valid_q;

  // The occupancy never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ <= DepthVal)
    else $error("deque occupancy above capacity");

  // A failed transaction leaves both pointers unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !ok_q) |-> ($stable(bot_q) && $stable(top_q)))
    else $error("pointers moved on a failed transaction");

  // A successful push grows the deque by one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && ok_q && (op_q == CMD_PUSH))
      |-> ({1'b0, occ} == {1'b0, $past(occ)} + 1'b1))
    else $error("push did not grow the deque by one");

  // A successful pop or steal shrinks the deque by one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && ok_q && (op_q != CMD_PUSH))
      |-> ({1'b0, occ} + 1'b1 == {1'b0, $past(occ)}))
    else $error("pop did not shrink the deque by one");

  // A success is reported only for a defined command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> (op_q == CMD_PUSH || op_q == CMD_POP || op_q == CMD_STEAL))
    else $error("success reported for an undefined command");

endmodule
